>>> design/drq_pkg.sv
// Package for the deadline ready queue: sizes, codes, item/result/command types
// and small helper functions. No dependencies.
`timescale 1ns / 1ps

package drq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = 5;
  localparam int TASK_W      = 8;
  localparam int TIME_W      = 48;
  localparam int SCALE_W     = 20;
  localparam int DELAY_W     = 20;
  localparam int SPAN_W      = SCALE_W + DELAY_W;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1000000);

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_WAKE   = 2'd2,
    MODE_STATUS = 2'd3
  } drq_mode_t;

  // push request kinds
  localparam logic [1:0] WAIT_RUN   = 2'd0;
  localparam logic [1:0] WAIT_TIMED = 2'd1;
  localparam logic [1:0] WAIT_EVENT = 2'd2;

  typedef enum logic [1:0] {
    KIND_RUN   = 2'd0,
    KIND_TIMED = 2'd1,
    KIND_EVENT = 2'd2
  } drq_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_WALK,
    S_FIN
  } drq_state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [TASK_W-1:0]  task_id;
    logic [1:0]         wait_kind;
    logic [DELAY_W-1:0] delay;
    logic [TIME_W-1:0]  now;
  } drq_item_t;

  typedef struct packed {
    logic              ok;
    logic [TASK_W-1:0] task_out;
    logic              deadline_valid;
    logic [TIME_W-1:0] soonest_deadline;
    logic [CNT_W-1:0]  event_waiting;
    logic [CNT_W-1:0]  pending;
  } drq_result_t;

  typedef struct packed {
    logic              load;
    logic              mul;
    logic              add;
    logic              walk_start;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_idx;
    logic              proc;
    logic              finish;
  } drq_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
  } drq_stat_t;

  // ring position of a logical index counted from the head
  function automatic logic [ADDR_W-1:0] drq_phys(input logic [ADDR_W-1:0] head,
                                                 input logic [ADDR_W-1:0] idx);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (ADDR_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (ADDR_W+1)'(QUEUE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // timed with zero delay and unknown kinds queue as runnable
  function automatic drq_kind_t drq_push_kind(input logic [1:0] wait_kind,
                                              input logic delay_nz);
    drq_kind_t k;
    k = KIND_RUN;
    if (wait_kind == WAIT_TIMED && delay_nz) begin
      k = KIND_TIMED;
    end else if (wait_kind == WAIT_EVENT) begin
      k = KIND_EVENT;
    end
    return k;
  endfunction

endpackage

>>> design/drq_if.sv
// Valid/ready channel interfaces for queue requests and results.
// Depends on drq_pkg for the payload types.
`timescale 1ns / 1ps

interface drq_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [drq_pkg::TASK_W-1:0]    task_id;
  logic [1:0]                    wait_kind;
  logic [drq_pkg::DELAY_W-1:0]   delay;
  logic [drq_pkg::TIME_W-1:0]    now;

  modport source (output valid, mode, task_id, wait_kind, delay, now, input ready);
  modport sink (input valid, mode, task_id, wait_kind, delay, now, output ready);
endinterface

interface drq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [drq_pkg::TASK_W-1:0]    task_out;
  logic                          deadline_valid;
  logic [drq_pkg::TIME_W-1:0]    soonest_deadline;
  logic [drq_pkg::CNT_W-1:0]     event_waiting;
  logic [drq_pkg::CNT_W-1:0]     pending;

  modport source (output valid, ok, task_out, deadline_valid, soonest_deadline,
                  event_waiting, pending, input ready);
  modport sink (input valid, ok, task_out, deadline_valid, soonest_deadline,
                event_waiting, pending, output ready);
endinterface

>>> design/drq_ctrl.sv
// Controller for the deadline ready queue: sequences accept, deadline math,
// the slot walk and the commit. Depends on drq_pkg.
`timescale 1ns / 1ps

module drq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  drq_pkg::drq_stat_t  stat,
  output drq_pkg::drq_cmd_t   cmd
);

  drq_pkg::drq_state_t state, state_next;
  logic [drq_pkg::CNT_W-1:0] idx, idx_next;
  logic proc, proc_next;
  logic out_vld, out_vld_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= drq_pkg::S_IDLE;
      idx     <= '0;
      proc    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      proc    <= proc_next;
      out_vld <= out_vld_next;
    end
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.proc       = proc;
    cmd.rd_idx     = idx[drq_pkg::ADDR_W-1:0];
    case (state)
      drq_pkg::S_IDLE: begin
        in_ready = ~rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = drq_pkg::S_MUL;
        end
      end
      drq_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = drq_pkg::S_ADD;
      end
      drq_pkg::S_ADD: begin
        cmd.add        = 1'b1;
        cmd.walk_start = 1'b1;
        idx_next       = '0;
        state_next     = drq_pkg::S_WALK;
      end
      drq_pkg::S_WALK: begin
        // one slot read a cycle; leave once the last read has been processed
        if (idx < stat.entry_count) begin
          cmd.rd_en = 1'b1;
          idx_next  = idx + drq_pkg::CNT_W'(1);
        end else if (!proc) begin
          state_next = drq_pkg::S_FIN;
        end
      end
      drq_pkg::S_FIN: begin
        if (!out_vld || out_ready) begin
          cmd.finish = 1'b1;
          state_next = drq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = drq_pkg::S_IDLE;
      end
    endcase
    proc_next    = cmd.rd_en;
    out_vld_next = cmd.finish | (out_vld & ~out_ready);
  end

  assign out_valid = out_vld;

endmodule

>>> design/drq_dpath.sv
// Datapath for the deadline ready queue: slot memories, head/count, deadline
// arithmetic, walk accumulators and the result register. Depends on drq_pkg.
`timescale 1ns / 1ps

module drq_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  drq_pkg::drq_cmd_t             cmd,
  input  drq_pkg::drq_item_t            item,
  input  logic                          cfg_we,
  input  logic [drq_pkg::SCALE_W-1:0]   cfg_wdata,
  output drq_pkg::drq_stat_t            stat,
  output drq_pkg::drq_result_t          res
);

  // slot storage, one read and one write per cycle
  logic [drq_pkg::TASK_W-1:0] slot_task     [drq_pkg::QUEUE_DEPTH];
  drq_pkg::drq_kind_t         slot_kind     [drq_pkg::QUEUE_DEPTH];
  logic [drq_pkg::TIME_W-1:0] slot_deadline [drq_pkg::QUEUE_DEPTH];

  logic [drq_pkg::SCALE_W-1:0] scale;
  logic [drq_pkg::ADDR_W-1:0]  head, head_next;
  logic [drq_pkg::CNT_W-1:0]   count, count_next;

  drq_pkg::drq_mode_t          mode_q;
  logic [drq_pkg::TASK_W-1:0]  task_q;
  logic [1:0]                  kind_q;
  logic [drq_pkg::DELAY_W-1:0] delay_q;
  logic [drq_pkg::TIME_W-1:0]  now_q;
  logic [drq_pkg::SPAN_W-1:0]  span;
  logic [drq_pkg::TIME_W-1:0]  dl;
  logic [drq_pkg::TIME_W:0]    dl_sum;

  logic [drq_pkg::ADDR_W-1:0]  rd_addr, rd_addr_q;
  logic [drq_pkg::TASK_W-1:0]  rd_task;
  drq_pkg::drq_kind_t          rd_kind, eff_kind;
  logic [drq_pkg::TIME_W-1:0]  rd_dl;

  // walk accumulators
  logic                        found;
  logic [drq_pkg::ADDR_W-1:0]  take_addr;
  logic [drq_pkg::TASK_W-1:0]  take_task;
  logic [drq_pkg::TASK_W-1:0]  head_task;
  drq_pkg::drq_kind_t          head_kind;
  logic [drq_pkg::TIME_W-1:0]  head_dl;
  logic [drq_pkg::CNT_W-1:0]   ev;
  logic                        dv;
  logic [drq_pkg::TIME_W-1:0]  best;

  logic                        take, wake_we;
  drq_pkg::drq_kind_t          push_kind;
  logic                        is_full;

  // commit values
  logic                        kind_we, ent_we;
  logic [drq_pkg::ADDR_W-1:0]  kind_waddr, ent_waddr;
  drq_pkg::drq_kind_t          kind_wdata;
  logic [drq_pkg::TASK_W-1:0]  task_wdata;
  logic [drq_pkg::TIME_W-1:0]  dl_wdata;
  logic                        ok_f, dv_f;
  logic [drq_pkg::TASK_W-1:0]  task_f;
  logic [drq_pkg::CNT_W-1:0]   ev_f;
  logic [drq_pkg::TIME_W-1:0]  best_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= drq_pkg::SCALE_RESET;
      head  <= '0;
      count <= '0;
    end else begin
      if (cfg_we) begin
        scale <= cfg_wdata;
      end
      if (cmd.finish) begin
        head  <= head_next;
        count <= count_next;
      end
    end
  end

  // item latch and deadline = now + delay * scale, saturated
  assign dl_sum = {1'b0, now_q} + (drq_pkg::TIME_W+1)'(span);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= drq_pkg::drq_mode_t'(item.mode);
      task_q  <= item.task_id;
      kind_q  <= item.wait_kind;
      delay_q <= item.delay;
      now_q   <= item.now;
    end
    if (cmd.mul) begin
      span <= drq_pkg::SPAN_W'(delay_q) * drq_pkg::SPAN_W'(scale);
    end
    if (cmd.add) begin
      dl <= dl_sum[drq_pkg::TIME_W] ? '1 : dl_sum[drq_pkg::TIME_W-1:0];
    end
  end

  assign rd_addr = drq_pkg::drq_phys(head, cmd.rd_idx);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_task   <= slot_task[rd_addr];
      rd_kind   <= slot_kind[rd_addr];
      rd_dl     <= slot_deadline[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_comb begin
    wake_we  = cmd.proc && mode_q == drq_pkg::MODE_WAKE && rd_kind == drq_pkg::KIND_EVENT;
    eff_kind = wake_we ? drq_pkg::KIND_RUN : rd_kind;
    take     = cmd.proc && mode_q == drq_pkg::MODE_POP && !found &&
               (rd_kind == drq_pkg::KIND_RUN ||
                (rd_kind == drq_pkg::KIND_TIMED && rd_dl <= now_q));
  end

  // the taken entry leaves the queue, so it is left out of the status sums
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      found <= 1'b0;
      ev    <= '0;
      dv    <= 1'b0;
      best  <= '0;
    end else if (cmd.proc) begin
      if (rd_addr_q == head) begin
        head_task <= rd_task;
        head_kind <= rd_kind;
        head_dl   <= rd_dl;
      end
      if (take) begin
        found     <= 1'b1;
        take_addr <= rd_addr_q;
        take_task <= rd_task;
      end else begin
        case (eff_kind)
          drq_pkg::KIND_EVENT: ev <= ev + drq_pkg::CNT_W'(1);
          drq_pkg::KIND_TIMED: begin
            if (!dv || rd_dl < best) begin
              best <= rd_dl;
            end
            dv <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    push_kind  = drq_pkg::drq_push_kind(kind_q, delay_q != '0);
    is_full    = count == drq_pkg::CNT_W'(drq_pkg::QUEUE_DEPTH);
    head_next  = head;
    count_next = count;
    ok_f       = 1'b0;
    task_f     = '0;
    ev_f       = ev;
    dv_f       = dv;
    best_f     = best;
    ent_we     = 1'b0;
    ent_waddr  = drq_pkg::drq_phys(head, count[drq_pkg::ADDR_W-1:0]);
    task_wdata = task_q;
    dl_wdata   = dl;
    kind_we    = wake_we;
    kind_waddr = rd_addr_q;
    kind_wdata = drq_pkg::KIND_RUN;
    if (cmd.finish) begin
      kind_we = 1'b0;
      case (mode_q)
        drq_pkg::MODE_PUSH: begin
          if (!is_full) begin
            ok_f       = 1'b1;
            ent_we     = 1'b1;
            kind_we    = 1'b1;
            kind_waddr = ent_waddr;
            kind_wdata = push_kind;
            count_next = count + drq_pkg::CNT_W'(1);
            case (push_kind)
              drq_pkg::KIND_EVENT: ev_f = ev + drq_pkg::CNT_W'(1);
              drq_pkg::KIND_TIMED: begin
                if (!dv || dl < best) begin
                  best_f = dl;
                end
                dv_f = 1'b1;
              end
              default: ;
            endcase
          end
        end
        drq_pkg::MODE_POP: begin
          if (found) begin
            // head entry fills the vacated slot, then the head advances
            ok_f       = 1'b1;
            task_f     = take_task;
            ent_we     = 1'b1;
            ent_waddr  = take_addr;
            task_wdata = head_task;
            dl_wdata   = head_dl;
            kind_we    = 1'b1;
            kind_waddr = take_addr;
            kind_wdata = head_kind;
            head_next  = drq_pkg::drq_phys(head, drq_pkg::ADDR_W'(1));
            count_next = count - drq_pkg::CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (kind_we) begin
      slot_kind[kind_waddr] <= kind_wdata;
    end
    if (ent_we) begin
      slot_task[ent_waddr]     <= task_wdata;
      slot_deadline[ent_waddr] <= dl_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.ok               <= ok_f;
      res.task_out         <= task_f;
      res.deadline_valid   <= dv_f;
      res.soonest_deadline <= best_f;
      res.event_waiting    <= ev_f;
      res.pending          <= count_next;
    end
  end

  assign stat.entry_count = count;

endmodule

>>> design/deadline_ready_queue.sv
// Top level of the deadline ready queue: controller plus datapath.
// Depends on drq_pkg, drq_if, drq_ctrl and drq_dpath.
//
//   port      kind        dir   carries
//   in_ch     drq_in_if   sink  mode, task_id, wait_kind, delay, now
//   out_ch    drq_out_if  src   ok, task_out, deadline_valid, soonest_deadline,
//                               event_waiting, pending
//   cfg_*     write port  in    ticks_per_delay_unit
//
// One item at a time: the next item is accepted only once the current one is
// committed, after a walk over every queued entry. The walk reads one queue slot
// a cycle through the single read port of the slot memory and then waits for the
// last read to land; multiply and saturating add are separate registered steps.
// A new item is taken while the previous result waits in the output register;
// the commit waits only if that register is still full.
// Synchronous reset: empty queue, head 0, scale 1000000; slots are not cleared.
`timescale 1ns / 1ps

module deadline_ready_queue (
  input  logic                        clk,
  input  logic                        rst,
  drq_in_if.sink                      in_ch,
  drq_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [drq_pkg::SCALE_W-1:0] cfg_wdata
);

  drq_pkg::drq_cmd_t    cmd;
  drq_pkg::drq_stat_t   stat;
  drq_pkg::drq_item_t   item;
  drq_pkg::drq_result_t res;

  assign item.mode      = in_ch.mode;
  assign item.task_id   = in_ch.task_id;
  assign item.wait_kind = in_ch.wait_kind;
  assign item.delay     = in_ch.delay;
  assign item.now       = in_ch.now;

  drq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  drq_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .res       (res)
  );

  assign out_ch.ok               = res.ok;
  assign out_ch.task_out         = res.task_out;
  assign out_ch.deadline_valid   = res.deadline_valid;
  assign out_ch.soonest_deadline = res.soonest_deadline;
  assign out_ch.event_waiting    = res.event_waiting;
  assign out_ch.pending          = res.pending;

endmodule
